[sv/lbu_pkg.sv]
// ----------------------------------------------------------------------------
// lbu_pkg
// shared types, constants and helpers of the bind/unbind unit
// ----------------------------------------------------------------------------
package lbu_pkg;

    localparam int STACK_DEPTH = 1024;
    localparam int SLOT_COUNT  = 256;
    localparam int STACK_AW    = $clog2(STACK_DEPTH);
    localparam int SLOT_AW     = $clog2(SLOT_COUNT);
    localparam int IDX_W       = $clog2(STACK_DEPTH + 1);
    localparam int QUEUE_DEPTH = 2;

    localparam logic [31:0] TOP_BIT  = 32'h8000_0000;
    localparam logic [31:0] ALL_ONES = 32'hffff_ffff;
    localparam logic [3:0]  NIBBLE   = 4'hf;

    localparam logic [2:0] OP_PUSH       = 3'd0;
    localparam logic [2:0] OP_BIND       = 3'd1;
    localparam logic [2:0] OP_UNBIND     = 3'd2;
    localparam logic [2:0] OP_DUNBIND    = 3'd3;
    localparam logic [2:0] OP_READ_SLOT  = 3'd4;
    localparam logic [2:0] OP_READ_STACK = 3'd5;

    localparam logic [1:0] FAULT_OK        = 2'd0;
    localparam logic [1:0] FAULT_UNDERFLOW = 2'd1;
    localparam logic [1:0] FAULT_RANGE     = 2'd2;
    localparam logic [1:0] FAULT_OVERFLOW  = 2'd3;

    typedef struct packed {
        logic [2:0]  operation;
        logic [31:0] tos;
        logic [7:0]  count_byte;
        logic [7:0]  slot_offset;
        logic [9:0]  read_address;
    } in_t;

    typedef struct packed {
        logic [10:0] stack_top;
        logic [31:0] read_value;
        logic [1:0]  fault;
    } out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NIL,
        ST_TOS,
        ST_POP_RD,
        ST_POP_WR,
        ST_MARK,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_FILL,
        ST_READ_WAIT,
        ST_DONE
    } state_t;

    // slots base-1 down to base-count must lie in the store
    function automatic logic slots_fit(input logic [16:0] base, input logic [15:0] count);
        logic [16:0] top;
        top = base - 17'd1;
        return (count == 16'd0) ||
               ((17'(count) <= base) && (32'(top) < 32'(SLOT_COUNT)));
    endfunction

endpackage

[sv/lbu_front.sv]
// ----------------------------------------------------------------------------
// lbu_front
// input side: accepts transactions and holds them in a short queue
// ----------------------------------------------------------------------------
module lbu_front
    import lbu_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic q_valid,
    input  logic q_pop,
    output in_t  q_data
);

    localparam int QP_W = $clog2(QUEUE_DEPTH);

    in_t               entry_reg [QUEUE_DEPTH];
    logic [QP_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QP_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QP_W:0]     fill_reg, fill_next;
    logic              push, pop;

    assign s_ready = (fill_reg < (QP_W+1)'(QUEUE_DEPTH));
    assign q_valid = (fill_reg != '0);
    assign q_data  = entry_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_pop && q_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = (32'(wr_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (32'(rd_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= s_data;
        end
    end

endmodule

[sv/lbu_back.sv]
// ----------------------------------------------------------------------------
// lbu_back
// execution side: sequencer over the stack and slot memories, result register
// ----------------------------------------------------------------------------
module lbu_back
    import lbu_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic q_valid,
    output logic q_pop,
    input  in_t  q_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    logic [31:0] stack_mem [STACK_DEPTH];
    logic [31:0] slot_mem  [SLOT_COUNT];

    logic                st_we, st_re, sl_we, sl_re;
    logic [STACK_AW-1:0] st_waddr, st_raddr;
    logic [SLOT_AW-1:0]  sl_waddr, sl_raddr;
    logic [31:0]         st_wdata, sl_wdata, st_rdata, sl_rdata;

    state_t          state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] ptr_reg, ptr_next;
    logic [2:0]      op_reg, op_next;
    logic [31:0]     tos_reg, tos_next;
    logic [3:0]      n1_reg, n1_next, n2_reg, n2_next;
    logic [7:0]      off_reg, off_next;
    logic [16:0]     cnt_reg, cnt_next;
    logic [16:0]     base_reg, base_next;
    logic [15:0]     count_reg, count_next;
    logic            set_idx_reg, set_idx_next;
    logic [31:0]     rv_reg, rv_next;
    logic [1:0]      fault_reg, fault_next;

    logic [3:0]      h_n1, h_n2;
    logic [4:0]      h_total;
    logic [IDX_W:0]  h_mpos;
    logic [31:0]     mk_word;
    logic [15:0]     mk_count;
    logic [16:0]     mk_base;
    logic [16:0]     slot_calc;

    assign h_n1     = q_data.count_byte[7:4] & NIBBLE;
    assign h_n2     = q_data.count_byte[3:0] & NIBBLE;
    assign h_total  = 5'(h_n1) + 5'(h_n2);
    assign h_mpos   = (h_n2 == 4'd0) ? ((IDX_W+1)'(idx_reg) + 1'b1)
                                     : ((IDX_W+1)'(idx_reg) - (IDX_W+1)'(h_n2 - 4'd1));
    assign mk_word  = (state_reg == ST_SCAN_CHK) ? st_rdata : q_data.tos;
    assign mk_count = ~mk_word[31:16];
    assign mk_base  = {2'b00, mk_word[15:1]} + 17'd1;

    assign m_valid             = (state_reg == ST_DONE);
    assign m_data.stack_top    = 11'(idx_reg);
    assign m_data.read_value   = rv_reg;
    assign m_data.fault        = fault_reg;

    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        ptr_next     = ptr_reg;
        op_next      = op_reg;
        tos_next     = tos_reg;
        n1_next      = n1_reg;
        n2_next      = n2_reg;
        off_next     = off_reg;
        cnt_next     = cnt_reg;
        base_next    = base_reg;
        count_next   = count_reg;
        set_idx_next = set_idx_reg;
        rv_next      = rv_reg;
        fault_next   = fault_reg;
        q_pop        = 1'b0;
        st_we = 1'b0; st_waddr = '0; st_wdata = '0; st_re = 1'b0; st_raddr = '0;
        sl_we = 1'b0; sl_waddr = '0; sl_wdata = '0; sl_re = 1'b0; sl_raddr = '0;
        slot_calc = '0;

        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop      = 1'b1;
                    op_next    = q_data.operation;
                    tos_next   = q_data.tos;
                    n1_next    = h_n1;
                    n2_next    = h_n2;
                    off_next   = q_data.slot_offset;
                    rv_next    = '0;
                    fault_next = FAULT_OK;
                    cnt_next   = '0;
                    state_next = ST_DONE;
                    case (q_data.operation)
                        OP_PUSH: begin
                            if (32'(idx_reg) >= STACK_DEPTH) begin
                                fault_next = FAULT_OVERFLOW;
                            end else begin
                                st_we    = 1'b1;
                                st_waddr = STACK_AW'(idx_reg);
                                st_wdata = q_data.tos;
                                idx_next = idx_reg + 1'b1;
                            end
                        end
                        OP_BIND: begin
                            if (h_n2 != 4'd0 && 32'(idx_reg) < 32'(h_n2 - 4'd1)) begin
                                fault_next = FAULT_UNDERFLOW;
                            end else if (32'(q_data.slot_offset) >= SLOT_COUNT ||
                                         9'(h_total) > 9'(q_data.slot_offset) + 9'd1) begin
                                fault_next = FAULT_RANGE;
                            end else if (32'(h_mpos) >= STACK_DEPTH) begin
                                fault_next = FAULT_OVERFLOW;
                            end else begin
                                ptr_next   = IDX_W'(h_mpos);
                                state_next = ST_NIL;
                            end
                        end
                        OP_UNBIND, OP_DUNBIND: begin
                            if (q_data.operation == OP_DUNBIND && (q_data.tos & TOP_BIT) != '0)
                            begin
                                if (!slots_fit(mk_base, mk_count)) begin
                                    fault_next = FAULT_RANGE;
                                end else begin
                                    base_next    = mk_base;
                                    count_next   = mk_count;
                                    set_idx_next = 1'b0;
                                    state_next   = ST_FILL;
                                end
                            end else if (idx_reg == '0) begin
                                fault_next = FAULT_UNDERFLOW;
                            end else begin
                                ptr_next   = idx_reg - 1'b1;
                                state_next = ST_SCAN_RD;
                            end
                        end
                        OP_READ_SLOT: begin
                            if (32'(q_data.read_address) >= SLOT_COUNT) begin
                                fault_next = FAULT_RANGE;
                            end else begin
                                sl_re      = 1'b1;
                                sl_raddr   = SLOT_AW'(q_data.read_address);
                                state_next = ST_READ_WAIT;
                            end
                        end
                        OP_READ_STACK: begin
                            if (32'(q_data.read_address) >= STACK_DEPTH) begin
                                fault_next = FAULT_OVERFLOW;
                            end else begin
                                st_re      = 1'b1;
                                st_raddr   = STACK_AW'(q_data.read_address);
                                state_next = ST_READ_WAIT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_NIL: begin
                if (cnt_reg < 17'(n1_reg)) begin
                    slot_calc = 17'(off_reg) - cnt_reg;
                    sl_we     = 1'b1;
                    sl_waddr  = SLOT_AW'(slot_calc);
                    sl_wdata  = '0;
                    cnt_next  = cnt_reg + 17'd1;
                end else begin
                    state_next = ST_TOS;
                end
            end
            ST_TOS: begin
                if (n2_reg == 4'd0) begin
                    st_we    = 1'b1;
                    st_waddr = STACK_AW'(idx_reg);
                    st_wdata = tos_reg;
                end else begin
                    slot_calc = 17'(off_reg) - 17'(n1_reg);
                    sl_we     = 1'b1;
                    sl_waddr  = SLOT_AW'(slot_calc);
                    sl_wdata  = tos_reg;
                end
                cnt_next   = 17'd1;
                state_next = ST_POP_RD;
            end
            ST_POP_RD: begin
                if (cnt_reg < 17'(n2_reg)) begin
                    st_re      = 1'b1;
                    st_raddr   = STACK_AW'(idx_reg - IDX_W'(cnt_reg));
                    state_next = ST_POP_WR;
                end else begin
                    state_next = ST_MARK;
                end
            end
            ST_POP_WR: begin
                slot_calc  = 17'(off_reg) - 17'(n1_reg) - cnt_reg;
                sl_we      = 1'b1;
                sl_waddr   = SLOT_AW'(slot_calc);
                sl_wdata   = st_rdata;
                cnt_next   = cnt_reg + 17'd1;
                state_next = ST_POP_RD;
            end
            ST_MARK: begin
                st_we      = 1'b1;
                st_waddr   = STACK_AW'(ptr_reg);
                st_wdata   = {~{11'd0, 5'(n1_reg) + 5'(n2_reg)}, {7'd0, off_reg, 1'b0}};
                idx_next   = ptr_reg;
                state_next = ST_DONE;
            end
            ST_SCAN_RD: begin
                st_re      = 1'b1;
                st_raddr   = STACK_AW'(ptr_reg);
                state_next = ST_SCAN_CHK;
            end
            ST_SCAN_CHK: begin
                if ((st_rdata & TOP_BIT) != '0) begin
                    if (!slots_fit(mk_base, mk_count)) begin
                        fault_next = FAULT_RANGE;
                        state_next = ST_DONE;
                    end else begin
                        base_next    = mk_base;
                        count_next   = mk_count;
                        set_idx_next = 1'b1;
                        state_next   = ST_FILL;
                    end
                end else if (ptr_reg == '0) begin
                    fault_next = FAULT_UNDERFLOW;
                    state_next = ST_DONE;
                end else begin
                    ptr_next   = ptr_reg - 1'b1;
                    state_next = ST_SCAN_RD;
                end
            end
            ST_FILL: begin
                if (cnt_reg < 17'(count_reg)) begin
                    slot_calc = base_reg - 17'd1 - cnt_reg;
                    sl_we     = 1'b1;
                    sl_waddr  = SLOT_AW'(slot_calc);
                    sl_wdata  = ALL_ONES;
                    cnt_next  = cnt_reg + 17'd1;
                end else begin
                    if (set_idx_reg) begin
                        idx_next = ptr_reg;
                    end
                    state_next = ST_DONE;
                end
            end
            ST_READ_WAIT: begin
                rv_next    = (op_reg == OP_READ_SLOT) ? sl_rdata : st_rdata;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            set_idx_reg <= 1'b0;
            cnt_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            set_idx_reg <= set_idx_next;
            cnt_reg     <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg   <= ptr_next;
        op_reg    <= op_next;
        tos_reg   <= tos_next;
        n1_reg    <= n1_next;
        n2_reg    <= n2_next;
        off_reg   <= off_next;
        base_reg  <= base_next;
        count_reg <= count_next;
        rv_reg    <= rv_next;
        fault_reg <= fault_next;
    end

    always_ff @(posedge aclk) begin
        if (st_we) begin
            stack_mem[st_waddr] <= st_wdata;
        end
        if (st_re) begin
            st_rdata <= stack_mem[st_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (sl_we) begin
            slot_mem[sl_waddr] <= sl_wdata;
        end
        if (sl_re) begin
            sl_rdata <= slot_mem[sl_raddr];
        end
    end

`ifndef ASSERT_OFF
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(idx_reg) <= STACK_DEPTH)
        else $error("stack index beyond depth");
    a_pop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> (state_reg == ST_IDLE))
        else $error("queue popped while busy");
    a_slot_we: assert property (@(posedge aclk) disable iff (!aresetn)
        sl_we |-> (state_reg != ST_IDLE && state_reg != ST_DONE))
        else $error("slot write outside a sequence");
    a_done_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && $past(state_reg == ST_DONE)) |-> $stable(idx_reg))
        else $error("stack index moved while result pending");
`endif

endmodule

[sv/lisp_bind_unbind_unit.sv]
// ----------------------------------------------------------------------------
// lisp_bind_unbind_unit
// bind, unbind and dunbind over an evaluation stack and variable slot store
//
// channel  dir  ports                     payload
// s_       in   s_valid s_ready s_data    in_t
// m_       out  m_valid m_ready m_data    out_t
//
// push and default ops go from idle to done; reads pass a read-wait state
// bind: nil slots, tos store, a read/write per stacked value, then the mark
// unbind reads and checks stack words back to a mark, then fills its slots
// reset clears state, index, counters and queue pointers, not the memories
// a two-entry queue accepts until full while a result waits on m_ready
// ----------------------------------------------------------------------------
module lisp_bind_unbind_unit
    import lbu_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    logic q_valid, q_pop;
    in_t  q_data;

    lbu_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_data  (q_data)
    );

    lbu_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_data  (q_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
